// ===== hdl/svpwm_min_max_duty_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SVPWM_MIN_MAX_DUTY_MACROS_SVH
`define SVPWM_MIN_MAX_DUTY_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SVPMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SVPMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/svpmd_pkg.sv =====
`default_nettype none
package svpmd_pkg;

  localparam int IN_W   = 16;         // alpha / beta commands
  localparam int BUS_W  = 16;         // bus voltage register
  localparam int DUTY_W = 16;         // Q1.15 duty
  localparam int PH_W   = IN_W + 16;  // phase voltage, input scaled by 2^15
  localparam int SUM_W  = PH_W + 1;   // max + min
  localparam int M_W    = PH_W + 3;   // dividend 2p - s + 32769u
  localparam int REM_W  = 32;         // non-negative dividend below 2^16 * u
  localparam int DEN_W  = BUS_W + 1;  // divisor 2u
  localparam int QB     = 15;         // quotient bits below full scale

  // clarke regs, max/min, offset, saturation check, QB divide steps, output reg
  localparam int PIPE_DEPTH = QB + 5;

  localparam logic signed [IN_W-1:0] SQRT3_HALF_Q15 = 16'sd28378;
  localparam logic [DUTY_W-1:0]      FULL_Q15       = 16'd32768;
  localparam logic [BUS_W-1:0]       BUS_RESET      = 16'd32767;

  typedef struct packed {
    logic neg;  // quotient below zero
    logic hi;   // quotient at or above full scale
  } sat_t;

  typedef struct packed {
    sat_t             sat;
    logic [REM_W-1:0] rem;
  } div_in_t;

endpackage
`default_nettype wire

// ===== hdl/svpmd_clarke.sv =====
`default_nettype none
// Inverse Clarke, phases scaled by 2^15; one register stage.
module svpmd_clarke (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [svpmd_pkg::IN_W-1:0]   u_alpha,
  input  logic signed [svpmd_pkg::IN_W-1:0]   u_beta,
  output logic signed [svpmd_pkg::PH_W-1:0]   ph_r [3]
);
  import svpmd_pkg::*;

  logic signed [PH_W-1:0] al_x15;
  logic signed [PH_W-1:0] al_x14;
  logic signed [PH_W-1:0] be_k;
  logic signed [PH_W-1:0] ph_nxt [3];

  assign al_x15 = {{(PH_W-IN_W-15){u_alpha[IN_W-1]}}, u_alpha, 15'd0};
  assign al_x14 = {{(PH_W-IN_W-14){u_alpha[IN_W-1]}}, u_alpha, 14'd0};
  assign be_k   = u_beta * SQRT3_HALF_Q15;

  assign ph_nxt[0] = al_x15;
  assign ph_nxt[1] = be_k - al_x14;
  assign ph_nxt[2] = -al_x14 - be_k;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= ph_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/svpmd_inject.sv =====
`default_nettype none
// Min-max injection and divide setup: three register stages.
//   A: s = max + min
//   B: m = 2p - s + 32769u  (so duty = floor(m / 2u) before clamping)
//   C: range flags, non-negative remainder for the divider
module svpmd_inject (
  input  logic                               clk,
  input  logic                               en,
  input  logic [svpmd_pkg::BUS_W-1:0]        u_eff,
  input  logic signed [svpmd_pkg::PH_W-1:0]  ph [3],
  output svpmd_pkg::div_in_t                 dv_r [3]
);
  import svpmd_pkg::*;

  logic signed [PH_W-1:0]  mx;
  logic signed [PH_W-1:0]  mn;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [PH_W-1:0]  ph_a_r [3];
  logic signed [M_W-1:0]   off;
  logic signed [M_W-1:0]   m_nxt [3];
  logic signed [M_W-1:0]   m_r [3];
  div_in_t                 dv_nxt [3];

  // stage A
  always_comb begin
    mx = ph[0];
    mn = ph[0];
    if (ph[1] > mx) mx = ph[1];
    if (ph[2] > mx) mx = ph[2];
    if (ph[1] < mn) mn = ph[1];
    if (ph[2] < mn) mn = ph[2];
    sum_nxt = SUM_W'(mx) + SUM_W'(mn);
  end

  // stage B
  assign off = $signed(M_W'({u_eff, 15'd0})) + $signed(M_W'(u_eff));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_nxt[i] = (M_W'(ph_a_r[i]) <<< 1) - M_W'(sum_r) + off;
    end
  end

  // stage C: hi when m >= 2^15 * 2u
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_nxt[i].sat.neg = m_r[i][M_W-1];
      dv_nxt[i].sat.hi  = !m_r[i][M_W-1] &&
                          (m_r[i][M_W-2:0] >= (M_W-1)'({u_eff, 16'd0}));
      dv_nxt[i].rem     = m_r[i][REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      ph_a_r <= ph;
      m_r    <= m_nxt;
      dv_r   <= dv_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/svpmd_div.sv =====
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Valid for rem < 2^QB * den; range flags ride along.
module svpmd_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [svpmd_pkg::DEN_W-1:0]       den,
  input  svpmd_pkg::div_in_t                din,
  output svpmd_pkg::sat_t                   sat,
  output logic [svpmd_pkg::QB-1:0]          q
);
  import svpmd_pkg::*;

  logic [REM_W-1:0] rem_r [QB];
  logic [QB-1:0]    q_r   [QB];
  sat_t             sat_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [QB-1:0]    q_in;
    sat_t             sat_in;
    logic [REM_W-1:0] sh;
    logic [REM_W:0]   diff;
    logic [REM_W-1:0] rem_nxt;
    logic [QB-1:0]    q_nxt;

    if (j == 0) begin : g_first
      assign rem_in = din.rem;
      assign q_in   = '0;
      assign sat_in = din.sat;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign sat_in = sat_r[j-1];
    end

    assign sh      = {{(REM_W-DEN_W){1'b0}}, den} << (QB - 1 - j);
    assign diff    = {1'b0, rem_in} - {1'b0, sh};
    assign rem_nxt = diff[REM_W] ? rem_in : diff[REM_W-1:0];
    assign q_nxt   = {q_in[QB-2:0], !diff[REM_W]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        sat_r[j] <= sat_in;
      end
    end
  end

  assign sat = sat_r[QB-1];
  assign q   = q_r[QB-1];

endmodule
`default_nettype wire

// ===== hdl/svpwm_min_max_duty.sv =====
// Space-vector PWM duty generator using min-max common-mode injection.
// Each input transaction (in_u_alpha, in_u_beta) yields one output transaction
// with three Q1.15 duties (32768 = always on), clamped to 0..32768. Duties are
// 0.5 + (p - (max+min)/2) / bus_voltage per phase, rounded to nearest with
// ties up; a bus_voltage of 0 acts as 1. The block takes one transaction per
// clock unless stalled and passes it through one inverse Clarke stage, three
// stages for injection and divide setup, 15 restoring-divide stages (one
// quotient bit each), and the output register. The whole pipeline advances
// together and holds while a result is stalled at the output; bubbles are not
// squeezed out. cfg_ready is always high; write cfg_bus_voltage only while no
// transaction is in flight.
`default_nettype none
module svpwm_min_max_duty (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [svpmd_pkg::IN_W-1:0] in_u_alpha,
  input  logic signed [svpmd_pkg::IN_W-1:0] in_u_beta,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [svpmd_pkg::DUTY_W-1:0]      out_duty_a,
  output logic [svpmd_pkg::DUTY_W-1:0]      out_duty_b,
  output logic [svpmd_pkg::DUTY_W-1:0]      out_duty_c,
  // bus voltage register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svpmd_pkg::BUS_W-1:0]       cfg_bus_voltage
);
  import svpmd_pkg::*;

  logic                    adv;          // whole pipeline moves
  logic [PIPE_DEPTH-1:0]   vld_r;        // valid per stage
  logic [BUS_W-1:0]        bus_r;
  logic [BUS_W-1:0]        u_eff;
  logic [DEN_W-1:0]        den;
  logic signed [PH_W-1:0]  ph_w [3];
  div_in_t                 dv_w [3];
  sat_t                    sat_w [3];
  logic [QB-1:0]           q_w [3];
  logic [DUTY_W-1:0]       duty_nxt [3];
  logic [DUTY_W-1:0]       duty_r [3];

  // Stall only when the output register holds an untaken result.
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[PIPE_DEPTH-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= BUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bus_r <= cfg_bus_voltage;
    end
  end

  // zero bus voltage divides as one
  assign u_eff = (bus_r == '0) ? BUS_W'(1) : bus_r;
  assign den   = {u_eff, 1'b0};

  svpmd_clarke u_clarke (
    .clk     (clk),
    .en      (adv),
    .u_alpha (in_u_alpha),
    .u_beta  (in_u_beta),
    .ph_r    (ph_w)
  );

  svpmd_inject u_inject (
    .clk   (clk),
    .en    (adv),
    .u_eff (u_eff),
    .ph    (ph_w),
    .dv_r  (dv_w)
  );

  // one divider per phase
  for (genvar i = 0; i < 3; i++) begin : g_phase
    svpmd_div u_div (
      .clk (clk),
      .en  (adv),
      .den (den),
      .din (dv_w[i]),
      .sat (sat_w[i]),
      .q   (q_w[i])
    );
  end

  // clamp: below zero -> 0, at/above full scale -> 32768
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sat_w[i].neg) begin
        duty_nxt[i] = '0;
      end else if (sat_w[i].hi) begin
        duty_nxt[i] = FULL_Q15;
      end else begin
        duty_nxt[i] = DUTY_W'(q_w[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      duty_r <= duty_nxt;
    end
  end

  assign out_duty_a = duty_r[0];
  assign out_duty_b = duty_r[1];
  assign out_duty_c = duty_r[2];

endmodule
`default_nettype wire

// ===== hdl/svpmd_checker.sv =====
`default_nettype none
`include "svpwm_min_max_duty_macros.svh"
// Port-level checks for the duty generator.
module svpmd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [svpmd_pkg::DUTY_W-1:0]      out_duty_a,
  input logic [svpmd_pkg::DUTY_W-1:0]      out_duty_b,
  input logic [svpmd_pkg::DUTY_W-1:0]      out_duty_c
);
  import svpmd_pkg::*;

  `SVPMD_ASSERT_NOW(a_duty_range, out_valid, (out_duty_a <= FULL_Q15) && (out_duty_b <= FULL_Q15) && (out_duty_c <= FULL_Q15), "duty above full scale")

  `SVPMD_ASSERT_NOW(a_stall_path, in_valid || !in_valid, in_stall == (out_valid && out_stall), "input stall does not follow output backpressure")

  `SVPMD_ASSERT_NOW(a_reset_empty, !$past(rst_n), !out_valid, "result shown right after reset")

  `SVPMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_duty_a) && $stable(out_duty_b) && $stable(out_duty_c), "stalled result changed")

endmodule

bind svpwm_min_max_duty svpmd_checker u_svpmd_checker (.*);
`default_nettype wire
